/* hdl/apll_pkg.sv */
// Shared types and codes for the pooled singly linked list.
`timescale 1ns / 1ps

package apll_pkg;

    localparam int LINK_W  = 7;
    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 32;

    localparam logic [LINK_W-1:0] LINK_NULL = '1;

    typedef enum logic
    {
        MODE_APPEND = 1'b0,
        MODE_DELETE = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_APPEND_WALK,
        S_DELETE_WALK,
        S_EMIT
    } state_t;

    typedef struct packed
    {
        mode_t                      mode;
        logic signed [VALUE_W-1:0]  value;
    } apll_in_t;

    typedef struct packed
    {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
    } apll_out_t;

endpackage

/* hdl/array_pool_linked_list.sv */
// Singly linked list in a fixed node pool: append at tail, delete first match.
//
//  channel | signals                       | transfer when
//  --------+-------------------------------+-----------------------
//  in      | in_valid, in_ready, in_data   | in_valid & in_ready
//  out     | out_valid, out_ready, out_data| out_valid & out_ready
//
// One item at a time. Append to an empty list or a full pool, or delete on an
// empty list, goes from idle straight to emit. Otherwise the walk visits up to
// POOL_NODES nodes; one link memory read per cycle sets the pace.
// Reset needs no clearing pass; node memories are only read after written.
// A new item is taken while the previous result waits in the output register;
// a stalled output holds the next result in its own stage.
`timescale 1ns / 1ps

module array_pool_linked_list
    import apll_pkg::*;
#(
    parameter int POOL_NODES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  apll_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output apll_out_t out_data
);

    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam logic [LINK_W-1:0] NODE_LIM  = LINK_W'(POOL_NODES);
    localparam logic [AW-1:0]     LAST_STEP = AW'(POOL_NODES - 1);

    logic [VALUE_W-1:0] value_mem [POOL_NODES];
    logic [LINK_W-1:0]  link_mem  [POOL_NODES];

    state_t             state_reg, state_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0]  next_free_reg, next_free_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [AW-1:0]      steps_reg, steps_next;
    logic [AW-1:0]      fresh_reg, fresh_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    apll_out_t          res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    apll_out_t          out_reg, out_next;

    logic [VALUE_W-1:0] value_rd_reg;
    logic [LINK_W-1:0]  link_rd_reg;

    logic [AW-1:0]      rd_addr;
    logic               value_we;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [LINK_W-1:0]  link_wdata;

    logic               accept;
    logic               pool_full;
    logic               head_end;
    logic               link_end;
    logic               last_step;
    logic               match;
    logic               out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign pool_full = (next_free_reg >= NODE_LIM);
    assign head_end  = (head_reg >= NODE_LIM);
    assign link_end  = (link_rd_reg >= NODE_LIM);
    assign last_step = (steps_reg == LAST_STEP);
    assign match     = (value_rd_reg == key_reg);
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_APPEND)
                        state_next = (pool_full || head_end) ? S_EMIT : S_APPEND_WALK;
                    else
                        state_next = head_end ? S_EMIT : S_DELETE_WALK;
                end
            end
            S_APPEND_WALK:
            begin
                if (link_end || last_step)
                    state_next = S_EMIT;
            end
            S_DELETE_WALK:
            begin
                if (match || link_end || last_step)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next       = head_reg;
        next_free_next  = next_free_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        steps_next      = steps_reg;
        fresh_next      = fresh_reg;
        key_next        = key_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        rd_addr         = link_rd_reg[AW-1:0];
        value_we        = 1'b0;
        link_we         = 1'b0;
        link_waddr      = cur_reg;
        link_wdata      = LINK_NULL;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = head_reg[AW-1:0];
                if (accept)
                begin
                    key_next        = in_data.value;
                    cur_next        = head_reg[AW-1:0];
                    steps_next      = '0;
                    prev_valid_next = 1'b0;
                    if (in_data.mode == MODE_APPEND)
                    begin
                        if (pool_full)
                        begin
                            res_next = '{status: ST_FULL, slot: '0};
                        end
                        else
                        begin
                            fresh_next     = next_free_reg[AW-1:0];
                            value_we       = 1'b1;
                            link_we        = 1'b1;
                            link_waddr     = next_free_reg[AW-1:0];
                            link_wdata     = LINK_NULL;
                            next_free_next = next_free_reg + LINK_W'(1);
                            res_next = '{status: ST_DONE,
                                         slot: SLOT_W'(next_free_reg[AW-1:0])};
                            if (head_end)
                                head_next = LINK_W'(next_free_reg[AW-1:0]);
                        end
                    end
                    else if (head_end)
                    begin
                        res_next = '{status: ST_NOTFOUND, slot: '0};
                    end
                end
            end
            S_APPEND_WALK:
            begin
                link_wdata = LINK_W'(fresh_reg);
                if (link_end)
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                end
                else if (last_step)
                begin
                    link_we    = 1'b1;
                    link_waddr = link_rd_reg[AW-1:0];
                end
                else
                begin
                    cur_next   = link_rd_reg[AW-1:0];
                    steps_next = steps_reg + AW'(1);
                end
            end
            S_DELETE_WALK:
            begin
                link_waddr = prev_reg;
                link_wdata = link_rd_reg;
                if (match)
                begin
                    if (prev_valid_reg)
                        link_we = 1'b1;
                    else
                        head_next = link_rd_reg;
                    res_next = '{status: ST_DONE, slot: SLOT_W'(cur_reg)};
                end
                else if (link_end || last_step)
                begin
                    res_next = '{status: ST_NOTFOUND, slot: '0};
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_valid_next = 1'b1;
                    cur_next        = link_rd_reg[AW-1:0];
                    steps_next      = steps_reg + AW'(1);
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= LINK_NULL;
            next_free_reg  <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            next_free_reg  <= next_free_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        fresh_reg <= fresh_next;
        key_reg   <= key_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // node memories, registered read
    always_ff @(posedge clk)
    begin
        if (value_we)
            value_mem[next_free_reg[AW-1:0]] <= in_data.value;
        value_rd_reg <= value_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        link_rd_reg <= link_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= NODE_LIM)
        else $error("allocation pointer beyond pool");

    a_head_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == LINK_NULL || head_reg < next_free_reg)
        else $error("list head points at unallocated slot");

    a_walk_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND_WALK || state_reg == S_DELETE_WALK)
        |-> (LINK_W'(cur_reg) < next_free_reg))
        else $error("walk reached unallocated slot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item produced no work");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule
